>>> hw/rtl/isc_pkg.sv
package isc_pkg;

    // fixed field widths of the item and result ports
    localparam int ACTION_W = 4;
    localparam int INDEX_W  = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;

    // default sizing of the entry store
    localparam int ISC_DEPTH  = 256;
    localparam int ISC_WORD_W = 32;

    // operation codes carried by the action field
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH    = 4'd0,
        ACT_POP     = 4'd1,
        ACT_PEEK    = 4'd2,
        ACT_GET     = 4'd3,
        ACT_SET     = 4'd4,
        ACT_DELETE  = 4'd5,
        ACT_REMOVE  = 4'd6,
        ACT_CURRENT = 4'd7,
        ACT_SHIFT   = 4'd8,
        ACT_CLEAR   = 4'd9
    } t_action;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        U_NONE,
        U_LATCH,
        U_PUSH,
        U_POP,
        U_RD_TOP,
        U_RD_IDX,
        U_RD_CUR,
        U_SHIFT,
        U_FILL_INIT,
        U_FILL,
        U_SET,
        U_DEL_INIT,
        U_MV_RD,
        U_MV_WR,
        U_DROP,
        U_SCAN_INIT,
        U_SCAN_RD,
        U_SCAN_NEXT,
        U_SCAN_HIT,
        U_CLEAR
    } t_uop;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_MV_RD,
        S_MV_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        t_uop    uop;
        logic    fin;
        t_status fin_st;
        logic    fin_rd;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_action action;
        logic    cnt_zero;
        logic    cnt_full;
        logic    idx_ge_cnt;
        logic    idx_ge_depth;
        logic    cur_ge_cnt;
        logic    fill_done;
        logic    walk_done;
        logic    scan_end;
        logic    hit;
        logic    out_free;
    } t_stat;

endpackage

>>> hw/rtl/isc_ctrl.sv
module isc_ctrl
    import isc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state  r_state, n_state;
    t_status r_fin_st, n_fin_st;
    logic    r_fin_rd, n_fin_rd;

    // state and pending result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fin_st <= ST_OK;
            r_fin_rd <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fin_st <= n_fin_st;
            r_fin_rd <= n_fin_rd;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_fin_st = r_fin_st;
        n_fin_rd = r_fin_rd;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_DECODE;
                    n_fin_st = ST_OK;
                    n_fin_rd = 1'b0;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.action)
                    ACT_PUSH: begin
                        if (i_stat.cnt_full) n_fin_st = ST_FULL;
                    end
                    ACT_POP, ACT_PEEK: begin
                        if (i_stat.cnt_zero) n_fin_st = ST_MISS;
                        else n_fin_rd = 1'b1;
                    end
                    ACT_GET: begin
                        if (i_stat.idx_ge_cnt) n_fin_st = ST_MISS;
                        else n_fin_rd = 1'b1;
                    end
                    ACT_SET: begin
                        if (i_stat.idx_ge_depth) n_fin_st = ST_FULL;
                        else n_state = S_FILL;
                    end
                    ACT_DELETE: begin
                        if (i_stat.idx_ge_cnt) n_fin_st = ST_MISS;
                        else n_state = S_MV_RD;
                    end
                    ACT_REMOVE: begin
                        n_state = S_SCAN_RD;
                    end
                    ACT_CURRENT, ACT_SHIFT: begin
                        if (i_stat.cur_ge_cnt) n_fin_st = ST_MISS;
                        else n_fin_rd = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FILL: begin
                if (i_stat.fill_done) n_state = S_DONE;
            end
            S_MV_RD: begin
                if (i_stat.walk_done) n_state = S_DONE;
                else n_state = S_MV_WR;
            end
            S_MV_WR: begin
                n_state = S_MV_RD;
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    n_state  = S_DONE;
                    n_fin_st = ST_MISS;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.hit) n_state = S_MV_RD;
                else n_state = S_SCAN_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        o_in_stall   = (r_state != S_IDLE);
        o_cmd.uop    = U_NONE;
        o_cmd.fin    = 1'b0;
        o_cmd.fin_st = r_fin_st;
        o_cmd.fin_rd = r_fin_rd;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_cmd.uop = U_LATCH;
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_PUSH: begin
                        if (!i_stat.cnt_full) o_cmd.uop = U_PUSH;
                    end
                    ACT_POP: begin
                        if (!i_stat.cnt_zero) o_cmd.uop = U_POP;
                    end
                    ACT_PEEK: begin
                        if (!i_stat.cnt_zero) o_cmd.uop = U_RD_TOP;
                    end
                    ACT_GET: begin
                        if (!i_stat.idx_ge_cnt) o_cmd.uop = U_RD_IDX;
                    end
                    ACT_SET: begin
                        if (!i_stat.idx_ge_depth) o_cmd.uop = U_FILL_INIT;
                    end
                    ACT_DELETE: begin
                        if (!i_stat.idx_ge_cnt) o_cmd.uop = U_DEL_INIT;
                    end
                    ACT_REMOVE: begin
                        o_cmd.uop = U_SCAN_INIT;
                    end
                    ACT_CURRENT: begin
                        if (!i_stat.cur_ge_cnt) o_cmd.uop = U_RD_CUR;
                    end
                    ACT_SHIFT: begin
                        if (!i_stat.cur_ge_cnt) o_cmd.uop = U_SHIFT;
                    end
                    ACT_CLEAR: begin
                        o_cmd.uop = U_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            S_FILL: begin
                o_cmd.uop = i_stat.fill_done ? U_SET : U_FILL;
            end
            S_MV_RD: begin
                o_cmd.uop = i_stat.walk_done ? U_DROP : U_MV_RD;
            end
            S_MV_WR: begin
                o_cmd.uop = U_MV_WR;
            end
            S_SCAN_RD: begin
                if (!i_stat.scan_end) o_cmd.uop = U_SCAN_RD;
            end
            S_SCAN_CMP: begin
                o_cmd.uop = i_stat.hit ? U_SCAN_HIT : U_SCAN_NEXT;
            end
            S_DONE: begin
                o_cmd.fin = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hw/rtl/isc_dpath.sv
module isc_dpath
    import isc_pkg::*;
#(
    parameter int DEPTH      = ISC_DEPTH,
    parameter int WORD_WIDTH = ISC_WORD_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_length,
    output logic [LEN_W-1:0]    o_cursor
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // entry store
    logic [WORD_WIDTH-1:0] mem [DEPTH];

    // latched item
    logic [ACTION_W-1:0]   r_action;
    logic [INDEX_W-1:0]    r_index;
    logic [WORD_WIDTH-1:0] r_value;

    // length, cursor, walk pointer and deleted position
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_cur, n_cur;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_pos, n_pos;

    logic [WORD_WIDTH-1:0] r_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;

    // result register
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_rd;
    t_status             r_out_st;
    logic [LEN_W-1:0]    r_out_len;
    logic [LEN_W-1:0]    r_out_cur;
    logic                out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // status toward the controller
    always_comb begin
        o_stat.action       = t_action'(r_action);
        o_stat.cnt_zero     = (r_cnt == '0);
        o_stat.cnt_full     = (32'(r_cnt) >= DEPTH);
        o_stat.idx_ge_cnt   = (32'(r_index) >= 32'(r_cnt));
        o_stat.idx_ge_depth = (32'(r_index) >= DEPTH);
        o_stat.cur_ge_cnt   = (r_cur >= r_cnt);
        o_stat.fill_done    = (32'(r_k) >= 32'(r_index));
        o_stat.walk_done    = (32'(r_k) + 32'd1 >= 32'(r_cnt));
        o_stat.scan_end     = (r_k >= r_cnt);
        o_stat.hit          = (r_rdata == r_value);
        o_stat.out_free     = out_free;
    end

    // micro-operation decode
    always_comb begin
        n_cnt     = r_cnt;
        n_cur     = r_cur;
        n_k       = r_k;
        n_pos     = r_pos;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_k);
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = AW'(r_k);
        case (i_cmd.uop)
            U_PUSH: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_cnt);
                mem_wdata = r_value;
                n_cnt     = r_cnt + 1'b1;
            end
            U_POP: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_cnt - 1'b1);
                n_cnt     = r_cnt - 1'b1;
            end
            U_RD_TOP: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_cnt - 1'b1);
            end
            U_RD_IDX: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_index);
            end
            U_RD_CUR: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_cur);
            end
            U_SHIFT: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_cur);
                n_cur     = r_cur + 1'b1;
            end
            U_FILL_INIT: begin
                n_k = r_cnt;
            end
            U_FILL: begin
                // zero one gap entry
                mem_we = 1'b1;
                n_k    = r_k + 1'b1;
            end
            U_SET: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_index);
                mem_wdata = r_value;
                if (32'(r_index) >= 32'(r_cnt)) begin
                    n_cnt = CW'(32'(r_index) + 32'd1);
                end
            end
            U_DEL_INIT: begin
                n_k   = CW'(r_index);
                n_pos = CW'(r_index);
            end
            U_MV_RD: begin
                mem_re    = 1'b1;
                mem_raddr = AW'(r_k + 1'b1);
            end
            U_MV_WR: begin
                // move the next entry down one place
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
                n_k       = r_k + 1'b1;
            end
            U_DROP: begin
                n_cnt = r_cnt - 1'b1;
                if (r_pos <= r_cur && r_cur != '0) begin
                    n_cur = r_cur - 1'b1;
                end
            end
            U_SCAN_INIT: begin
                n_k = '0;
            end
            U_SCAN_RD: begin
                mem_re = 1'b1;
            end
            U_SCAN_NEXT: begin
                n_k = r_k + 1'b1;
            end
            U_SCAN_HIT: begin
                n_pos = r_k;
            end
            U_CLEAR: begin
                n_cnt = '0;
                n_cur = '0;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cur <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_cur <= n_cur;
        end
    end

    // item capture and walk registers
    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_pos <= n_pos;
        if (i_cmd.uop == U_LATCH) begin
            r_action <= i_action;
            r_index  <= i_index;
            r_value  <= WORD_WIDTH'(i_value);
        end
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // memory read port
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // result register and output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_rd  <= i_cmd.fin_rd ? VALUE_W'(r_rdata) : '0;
            r_out_st  <= i_cmd.fin_st;
            r_out_len <= LEN_W'(r_cnt);
            r_out_cur <= LEN_W'(r_cur);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_status     = r_out_st;
    assign o_length     = r_out_len;
    assign o_cursor     = r_out_cur;

endmodule

>>> hw/rtl/indexed_stack_with_cursor.sv
// Bounded word stack with a read cursor, one result per item. An item is taken only while
// the block is idle and its result leaves through an output register, so the next item is
// accepted while a result still waits. Push, pop, peek, get, current, shift, clear and
// rejected items go from decode straight to the result; set first writes a zero to each
// gap entry; delete moves each entry after the index down by a read and a write; remove
// reads and compares entries in turn, then moves the entries after a hit down in the same
// way, one read-then-write pair per entry moved. The store holds no reset value and
// needs no clearing pass: only entries below the length are ever read.
module indexed_stack_with_cursor
    import isc_pkg::*;
#(
    parameter int DEPTH      = ISC_DEPTH,
    parameter int WORD_WIDTH = ISC_WORD_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [INDEX_W-1:0]  i_index,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [LEN_W-1:0]    o_length,
    output logic [LEN_W-1:0]    o_cursor
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    isc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // store, counters and result register
    isc_dpath #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_cursor     (o_cursor)
    );

`ifndef ASSERT_OFF
    // an accepted item holds off the next one until its result is loaded into the output register
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted back to back");

    // a result is only loaded into a free output slot
    a_fin_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> stat.out_free)
        else $error("result loaded over a pending result");

    // a loaded result is presented in the next cycle
    a_fin_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> o_out_valid)
        else $error("loaded result not presented");

    // no walk or scan step while the result is waiting
    a_no_uop_at_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> (cmd.uop == U_NONE))
        else $error("datapath step issued with result");
`endif

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import isc_pkg::*;

    localparam int STACK_DEPTH = ISC_DEPTH;
    localparam int CYCLE_LIMIT = 12_000_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int CALM_TAIL = 150;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 4'd15;

    // one result of the block
    typedef struct {
        logic [VALUE_W-1:0] rd;
        t_status            st;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   cur;
    } t_stack_result;

    // one row of directed stimulus, with an optional hand-typed result
    typedef struct {
        logic [ACTION_W-1:0] act;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        bit                  typed;
        t_stack_result       res;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action;
    logic [INDEX_W-1:0]  i_index;
    logic [VALUE_W-1:0]  i_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [VALUE_W-1:0]  o_read_value;
    logic [STATUS_W-1:0] o_status;
    logic [LEN_W-1:0]    o_length;
    logic [LEN_W-1:0]    o_cursor;

    // mirror of the stack contents, length and cursor
    logic [VALUE_W-1:0] mirror_mem [STACK_DEPTH];
    int unsigned        mirror_len;
    int unsigned        mirror_cur;

    t_stack_result pending_results [$];
    t_stack_result head;
    t_stack_result no_result = '{32'd0, ST_OK, 9'd0, 9'd0};
    int            fail_count = 0;
    int            cycle_count = 0;
    int            idle_level = 0;
    int            push_pct = 30;

    t_stim_row dir_rows [28] = '{
        '{ACT_POP,     9'd0,   32'd0,        1'b1, '{32'd0, ST_MISS, 9'd0, 9'd0}},
        '{ACT_PEEK,    9'd0,   32'd0,        1'b1, '{32'd0, ST_MISS, 9'd0, 9'd0}},
        '{ACT_SHIFT,   9'd0,   32'd0,        1'b1, '{32'd0, ST_MISS, 9'd0, 9'd0}},
        '{ACT_DELETE,  9'd0,   32'd0,        1'b1, '{32'd0, ST_MISS, 9'd0, 9'd0}},
        '{ACT_REMOVE,  9'd0,   32'd0,        1'b1, '{32'd0, ST_MISS, 9'd0, 9'd0}},
        '{ACT_SET,     9'd256, 32'd1,        1'b1, '{32'd0, ST_FULL, 9'd0, 9'd0}},
        '{ACT_UNUSED,  9'd511, 32'hFFFFFFFF, 1'b1, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_PUSH,    9'd0,   32'hFFFFFFFF, 1'b1, '{32'd0, ST_OK, 9'd1, 9'd0}},
        '{ACT_PUSH,    9'd0,   32'd0,        1'b1, '{32'd0, ST_OK, 9'd2, 9'd0}},
        '{ACT_SHIFT,   9'd0,   32'd0,        1'b1, '{32'hFFFFFFFF, ST_OK, 9'd2, 9'd1}},
        '{ACT_SET,     9'd5,   32'hA5A5A5A5, 1'b1, '{32'd0, ST_OK, 9'd6, 9'd1}},
        '{ACT_GET,     9'd3,   32'd0,        1'b1, '{32'd0, ST_OK, 9'd6, 9'd1}},
        '{ACT_GET,     9'd5,   32'd0,        1'b1, '{32'hA5A5A5A5, ST_OK, 9'd6, 9'd1}},
        '{ACT_CURRENT, 9'd0,   32'd0,        1'b0, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_DELETE,  9'd0,   32'd0,        1'b1, '{32'd0, ST_OK, 9'd5, 9'd0}},
        '{ACT_REMOVE,  9'd0,   32'hA5A5A5A5, 1'b1, '{32'd0, ST_OK, 9'd4, 9'd0}},
        '{ACT_REMOVE,  9'd0,   32'h12345678, 1'b1, '{32'd0, ST_MISS, 9'd4, 9'd0}},
        '{ACT_SHIFT,   9'd0,   32'd0,        1'b0, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_SHIFT,   9'd0,   32'd0,        1'b0, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_POP,     9'd0,   32'd0,        1'b0, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_POP,     9'd0,   32'd0,        1'b0, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_CURRENT, 9'd0,   32'd0,        1'b0, '{32'd0, ST_OK, 9'd0, 9'd0}},
        '{ACT_SET,     9'd255, 32'h5A5A5A5A, 1'b1, '{32'd0, ST_OK, 9'd256, 9'd2}},
        '{ACT_PUSH,    9'd0,   32'd1,        1'b1, '{32'd0, ST_FULL, 9'd256, 9'd2}},
        '{ACT_PEEK,    9'd0,   32'd0,        1'b1, '{32'h5A5A5A5A, ST_OK, 9'd256, 9'd2}},
        '{ACT_GET,     9'd511, 32'd0,        1'b1, '{32'd0, ST_MISS, 9'd256, 9'd2}},
        '{ACT_POP,     9'd0,   32'd0,        1'b1, '{32'h5A5A5A5A, ST_OK, 9'd255, 9'd2}},
        '{ACT_CLEAR,   9'd0,   32'd0,        1'b1, '{32'd0, ST_OK, 9'd0, 9'd0}}
    };

    indexed_stack_with_cursor uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_length     (o_length),
        .o_cursor     (o_cursor)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // take one entry out, close the gap and pull the cursor back if needed
    function automatic void drop_entry(input int unsigned pos);
        int unsigned k;
        for (k = pos; k + 1 < mirror_len; k++) begin
            mirror_mem[k] = mirror_mem[k + 1];
        end
        mirror_len--;
        if (pos <= mirror_cur && mirror_cur > 0) begin
            mirror_cur--;
        end
    endfunction

    // apply one operation to the mirror and return the result it gives
    function automatic t_stack_result apply_action(input logic [ACTION_W-1:0] act,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [VALUE_W-1:0] val);
        t_stack_result r;
        int unsigned   k;
        int            hit;
        r.rd = '0;
        r.st = ST_OK;
        hit = -1;
        case (act)
            ACT_PUSH: begin
                if (mirror_len >= STACK_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    mirror_mem[mirror_len] = val;
                    mirror_len++;
                end
            end
            ACT_POP: begin
                if (mirror_len == 0) begin
                    r.st = ST_MISS;
                end else begin
                    mirror_len--;
                    r.rd = mirror_mem[mirror_len];
                end
            end
            ACT_PEEK: begin
                if (mirror_len == 0) r.st = ST_MISS;
                else r.rd = mirror_mem[mirror_len - 1];
            end
            ACT_GET: begin
                if (idx >= mirror_len) r.st = ST_MISS;
                else r.rd = mirror_mem[idx];
            end
            ACT_SET: begin
                if (idx >= STACK_DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    for (k = mirror_len; k < idx; k++) begin
                        mirror_mem[k] = '0;
                    end
                    mirror_mem[idx] = val;
                    if (idx + 1 > mirror_len) mirror_len = idx + 1;
                end
            end
            ACT_DELETE: begin
                if (idx >= mirror_len) r.st = ST_MISS;
                else drop_entry(idx);
            end
            ACT_REMOVE: begin
                for (k = 0; k < mirror_len; k++) begin
                    if (hit < 0 && mirror_mem[k] == val) hit = k;
                end
                if (hit < 0) begin
                    r.st = ST_MISS;
                end else begin
                    drop_entry(hit);
                end
            end
            ACT_CURRENT: begin
                if (mirror_cur >= mirror_len) r.st = ST_MISS;
                else r.rd = mirror_mem[mirror_cur];
            end
            ACT_SHIFT: begin
                if (mirror_cur >= mirror_len) begin
                    r.st = ST_MISS;
                end else begin
                    r.rd = mirror_mem[mirror_cur];
                    mirror_cur++;
                end
            end
            ACT_CLEAR: begin
                mirror_len = 0;
                mirror_cur = 0;
            end
            default: begin
            end
        endcase
        r.len = LEN_W'(mirror_len);
        r.cur = LEN_W'(mirror_cur);
        return r;
    endfunction

    // offer one item, wait for the transfer, then record what it should return
    task automatic drive_item(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val, input bit typed,
                              input t_stack_result want);
        t_stack_result pred;
        int            gap_pct;
        gap_pct = (idle_level == 0) ? 0 : (idle_level == 1) ? 12 : 35;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_index    <= idx;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pred = apply_action(act, idx, val);
        pending_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    // choose an index: mostly inside the stack, sometimes at or past its end
    function automatic logic [INDEX_W-1:0] pick_index();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return INDEX_W'($urandom_range(0, 511));
            1: return INDEX_W'(mirror_len);
            2: return INDEX_W'(mirror_len + $urandom_range(0, 8));
            3: return INDEX_W'($urandom_range(STACK_DEPTH - 1, STACK_DEPTH));
            default: return (mirror_len == 0) ? '0 : INDEX_W'($urandom_range(0, mirror_len - 1));
        endcase
    endfunction

    // build one random item shaped by the current stack contents
    task automatic pick_item(output logic [ACTION_W-1:0] act, output logic [INDEX_W-1:0] idx,
                             output logic [VALUE_W-1:0] val);
        int unsigned r;
        int unsigned vsel;
        if ($urandom_range(0, 99) < push_pct) begin
            act = ACT_PUSH;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 14)      act = ACT_POP;
            else if (r < 20) act = ACT_PEEK;
            else if (r < 32) act = ACT_GET;
            else if (r < 44) act = ACT_SET;
            else if (r < 55) act = ACT_DELETE;
            else if (r < 66) act = ACT_REMOVE;
            else if (r < 75) act = ACT_CURRENT;
            else if (r < 88) act = ACT_SHIFT;
            else if (r < 89) act = ACT_CLEAR;
            else if (r < 93) act = ACTION_W'($urandom_range(10, 15));
            else             act = ACT_PUSH;
        end
        idx = pick_index();
        // small values repeat so that removes find duplicates
        vsel = $urandom_range(0, 3);
        if (vsel == 1) begin
            val = VALUE_W'($urandom_range(0, 3));
        end else if (vsel >= 2 && act == ACT_REMOVE && mirror_len > 0) begin
            val = mirror_mem[$urandom_range(0, mirror_len - 1)];
        end else begin
            val = $urandom;
        end
    endtask

    // random stall bursts on the result side
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_level != 0 && $urandom_range(0, 99) < idle_level * 10) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: read_value %0h status %0d",
                       o_read_value, o_status);
                fail_count++;
            end else begin
                head = pending_results.pop_front();
                if (o_read_value !== head.rd) begin
                    $error("read_value: expected %0h, got %0h", head.rd, o_read_value);
                    fail_count++;
                end
                if (o_status !== head.st) begin
                    $error("status: expected %0d, got %0d", head.st, o_status);
                    fail_count++;
                end
                if (o_length !== head.len) begin
                    $error("length: expected %0d, got %0d", head.len, o_length);
                    fail_count++;
                end
                if (o_cursor !== head.cur) begin
                    $error("cursor: expected %0d, got %0d", head.cur, o_cursor);
                    fail_count++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // reset, directed rows, random items, drain
    initial begin
        logic [ACTION_W-1:0] act;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        int                  counted;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_action   = '0;
        i_index    = '0;
        i_value    = '0;
        mirror_len = 0;
        mirror_cur = 0;
        counted    = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed rows with light idling
        idle_level = 1;
        foreach (dir_rows[n]) begin
            drive_item(dir_rows[n].act, dir_rows[n].idx, dir_rows[n].val,
                       dir_rows[n].typed, dir_rows[n].res);
        end

        // random items; ignored action codes are not counted
        while (counted < RANDOM_ITEMS) begin
            if (counted % 100 == 0) idle_level = $urandom_range(0, 2);
            if (counted % 150 == 0) push_pct = (counted % 450 == 0) ? 15 :
                                               (counted % 300 == 0) ? 55 : 30;
            if (counted >= RANDOM_ITEMS - CALM_TAIL) idle_level = 0;
            pick_item(act, idx, val);
            drive_item(act, idx, val, 1'b0, no_result);
            if (act <= ACT_CLEAR) counted++;
        end
        i_in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
